// ----- hdl/json_string_unescape_utf8_macros.svh -----
// Assertion helpers for the JSON string unescaper.
// Both sample on the rising edge of clk and stay quiet while rst_n is low.
`ifndef JSON_STRING_UNESCAPE_UTF8_MACROS_SVH
`define JSON_STRING_UNESCAPE_UTF8_MACROS_SVH

// The consequent must hold in the same cycle as the antecedent.
`define JSU_ASSERT_NOW(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define JSU_ASSERT_NEXT(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- hdl/jsu_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none

package jsu_pkg;

    // Most bytes one character can release (high surrogate, '?', one plain byte)
    localparam int EMIT_MAX   = 5;
    localparam int EMIT_CNT_W = $clog2(EMIT_MAX + 1);

    // Job queue between the decoder and the output serializer
    localparam int QDEPTH  = 2;
    localparam int QPTR_W  = (QDEPTH > 1) ? $clog2(QDEPTH) : 1;
    localparam int QCNT_W  = $clog2(QDEPTH + 1);

    localparam logic [15:0] CAP_RESET  = 16'd260;
    localparam logic [2:0]  HEX_DIGITS = 3'd4;

    // Characters with a meaning of their own
    localparam logic [7:0] CH_NUL    = 8'h00;
    localparam logic [7:0] CH_QUOTE  = 8'h22;
    localparam logic [7:0] CH_BSLASH = 8'h5C;
    localparam logic [7:0] CH_QMARK  = 8'h3F;
    localparam logic [7:0] CH_LOW_N  = 8'h6E;
    localparam logic [7:0] CH_LOW_T  = 8'h74;
    localparam logic [7:0] CH_LOW_R  = 8'h72;
    localparam logic [7:0] CH_LOW_B  = 8'h62;
    localparam logic [7:0] CH_LOW_F  = 8'h66;
    localparam logic [7:0] CH_LOW_U  = 8'h75;

    localparam logic [7:0] CTL_LF = 8'h0A;
    localparam logic [7:0] CTL_HT = 8'h09;
    localparam logic [7:0] CTL_CR = 8'h0D;
    localparam logic [7:0] CTL_BS = 8'h08;
    localparam logic [7:0] CTL_FF = 8'h0C;

    // Surrogate ranges
    localparam logic [15:0] HI_SUR_MIN = 16'hD800;
    localparam logic [15:0] HI_SUR_MAX = 16'hDBFF;
    localparam logic [15:0] LO_PFX_MIN = 16'h00DC;
    localparam logic [15:0] LO_PFX_MAX = 16'h00DF;
    localparam logic [15:0] LO_NIBBLE  = 16'h000D;
    localparam logic [20:0] SUPP_BASE  = 21'h10000;

    typedef struct packed {
        logic                             ok;
        logic [3:0]                       val;
    } hex_t;

    typedef struct packed {
        logic [EMIT_MAX-1:0][7:0]         bytes;
        logic [EMIT_CNT_W-1:0]            count;
    } emit_t;

    // One queue entry: the bytes released by one character, then the optional close
    typedef struct packed {
        logic [EMIT_MAX-1:0][7:0]         bytes;
        logic [EMIT_CNT_W-1:0]            count;
        logic                             done;
    } job_t;

    typedef struct packed {
        logic                             valid;
        job_t                             job;
    } q_head_t;

    function automatic hex_t hex_digit(logic [7:0] c);
        hex_t r;
        r = '0;
        if (c inside {[8'h30:8'h39]})
        begin
            r.ok  = 1'b1;
            r.val = c[3:0];
        end
        else if (c inside {[8'h61:8'h66], [8'h41:8'h46]})
        begin
            r.ok  = 1'b1;
            r.val = c[3:0] + 4'd9;
        end
        return r;
    endfunction

    function automatic emit_t emit_byte(emit_t e, logic [7:0] b);
        emit_t r;
        r = e;
        if (r.count < EMIT_CNT_W'(EMIT_MAX))
        begin
            r.bytes[r.count] = b;
            r.count          = r.count + EMIT_CNT_W'(1);
        end
        return r;
    endfunction

    // Append the UTF-8 form of a code point
    function automatic emit_t emit_code(emit_t e, logic [20:0] v);
        emit_t r;
        r = e;
        if (v < 21'h80)
        begin
            r = emit_byte(r, v[7:0]);
        end
        else if (v < 21'h800)
        begin
            r = emit_byte(r, {3'b110, v[10:6]});
            r = emit_byte(r, {2'b10, v[5:0]});
        end
        else if (v < 21'h10000)
        begin
            r = emit_byte(r, {4'b1110, v[15:12]});
            r = emit_byte(r, {2'b10, v[11:6]});
            r = emit_byte(r, {2'b10, v[5:0]});
        end
        else
        begin
            r = emit_byte(r, {5'b11110, v[20:18]});
            r = emit_byte(r, {2'b10, v[17:12]});
            r = emit_byte(r, {2'b10, v[11:6]});
            r = emit_byte(r, {2'b10, v[5:0]});
        end
        return r;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/jsu_front.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jsu_front (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [15:0]       cfg_wr_data,
    input  wire logic [7:0]        char_byte,
    input  wire logic              first_char,
    input  wire logic              end_of_text,
    input  wire logic              take,
    output jsu_pkg::job_t          job,
    output logic                   job_live
);

    typedef enum logic [2:0] {
        M_IDLE,
        M_NORMAL,
        M_ESC,
        M_HEX,
        M_HIGH,
        M_HIGH_BS,
        M_HEX2,
        M_DONE
    } mode_t;

    mode_t       mode_reg, mode_next, cur_mode;
    logic [2:0]  hex_cnt_reg, hex_cnt_next, hc, hc_inc;
    logic [15:0] code_reg, code_next, cv, cv_sh;
    logic [15:0] high_reg, high_next, ph;
    logic [15:0] bw_reg, bw_next, bw;
    logic [15:0] cap_reg;
    logic [15:0] room;
    logic [16:0] bw_plus1;
    logic [20:0] pair_code;
    logic        fin, hv, maybe_low, done, do_plain, do_esc;
    logic [jsu_pkg::EMIT_CNT_W-1:0] keep;
    jsu_pkg::hex_t  hx;
    jsu_pkg::emit_t e;

    // Classify one character and collect the bytes it releases
    always_comb
    begin
        fin      = end_of_text || (char_byte == jsu_pkg::CH_NUL);
        cur_mode = first_char ? M_NORMAL : mode_reg;
        hc       = first_char ? 3'd0  : hex_cnt_reg;
        cv       = first_char ? 16'd0 : code_reg;
        ph       = first_char ? 16'd0 : high_reg;
        bw       = first_char ? 16'd0 : bw_reg;

        hx        = jsu_pkg::hex_digit(char_byte);
        hv        = hx.ok && !fin;
        cv_sh     = {cv[11:0], hx.val};
        hc_inc    = hc + 3'd1;
        pair_code = jsu_pkg::SUPP_BASE + {1'b0, ph[9:0], cv_sh[9:0]};
        if (hc_inc == 3'd1)
            maybe_low = (cv_sh == jsu_pkg::LO_NIBBLE);
        else if (hc_inc == 3'd2)
            maybe_low = (cv_sh >= jsu_pkg::LO_PFX_MIN) && (cv_sh <= jsu_pkg::LO_PFX_MAX);
        else
            maybe_low = 1'b1;

        mode_next    = cur_mode;
        hex_cnt_next = hc;
        code_next    = cv;
        high_next    = ph;
        e            = '0;
        done         = 1'b0;
        do_plain     = 1'b0;
        do_esc       = 1'b0;

        case (cur_mode)
            M_NORMAL:
            begin
                do_plain = 1'b1;
            end
            M_ESC:
            begin
                do_esc = 1'b1;
            end
            M_HEX:
            begin
                if (!hv)
                begin
                    e        = jsu_pkg::emit_byte(e, jsu_pkg::CH_QMARK);
                    do_plain = 1'b1;
                end
                else
                begin
                    code_next    = cv_sh;
                    hex_cnt_next = hc_inc;
                    if (hc_inc >= jsu_pkg::HEX_DIGITS)
                    begin
                        if ((cv_sh >= jsu_pkg::HI_SUR_MIN) && (cv_sh <= jsu_pkg::HI_SUR_MAX))
                        begin
                            high_next = cv_sh;
                            mode_next = M_HIGH;
                        end
                        else
                        begin
                            e         = jsu_pkg::emit_code(e, {5'd0, cv_sh});
                            mode_next = M_NORMAL;
                        end
                    end
                end
            end
            M_HIGH:
            begin
                if (!fin && (char_byte == jsu_pkg::CH_BSLASH))
                    mode_next = M_HIGH_BS;
                else
                begin
                    e        = jsu_pkg::emit_code(e, {5'd0, ph});
                    do_plain = 1'b1;
                end
            end
            M_HIGH_BS:
            begin
                if (!fin && (char_byte == jsu_pkg::CH_LOW_U))
                begin
                    mode_next    = M_HEX2;
                    hex_cnt_next = 3'd0;
                    code_next    = 16'd0;
                end
                else
                begin
                    e      = jsu_pkg::emit_code(e, {5'd0, ph});
                    do_esc = 1'b1;
                end
            end
            M_HEX2:
            begin
                if (!hv)
                begin
                    // broken pair: flush the high half, then the short escape
                    e        = jsu_pkg::emit_code(e, {5'd0, ph});
                    e        = jsu_pkg::emit_byte(e, jsu_pkg::CH_QMARK);
                    do_plain = 1'b1;
                end
                else
                begin
                    code_next    = cv_sh;
                    hex_cnt_next = hc_inc;
                    if (!maybe_low)
                    begin
                        e         = jsu_pkg::emit_code(e, {5'd0, ph});
                        mode_next = M_HEX;
                    end
                    else if (hc_inc >= jsu_pkg::HEX_DIGITS)
                    begin
                        e         = jsu_pkg::emit_code(e, pair_code);
                        mode_next = M_NORMAL;
                    end
                end
            end
            default:
            begin
                mode_next = cur_mode;
            end
        endcase

        // Handle the character as ordinary text
        if (do_plain)
        begin
            mode_next = M_NORMAL;
            if (fin || (char_byte == jsu_pkg::CH_QUOTE))
            begin
                done      = 1'b1;
                mode_next = M_DONE;
            end
            else if (char_byte == jsu_pkg::CH_BSLASH)
                mode_next = M_ESC;
            else
                e = jsu_pkg::emit_byte(e, char_byte);
        end

        // Handle the character after a backslash
        if (do_esc)
        begin
            if (fin)
            begin
                e         = jsu_pkg::emit_byte(e, jsu_pkg::CH_BSLASH);
                done      = 1'b1;
                mode_next = M_DONE;
            end
            else
            begin
                mode_next = M_NORMAL;
                case (char_byte)
                    jsu_pkg::CH_LOW_N: e = jsu_pkg::emit_byte(e, jsu_pkg::CTL_LF);
                    jsu_pkg::CH_LOW_T: e = jsu_pkg::emit_byte(e, jsu_pkg::CTL_HT);
                    jsu_pkg::CH_LOW_R: e = jsu_pkg::emit_byte(e, jsu_pkg::CTL_CR);
                    jsu_pkg::CH_LOW_B: e = jsu_pkg::emit_byte(e, jsu_pkg::CTL_BS);
                    jsu_pkg::CH_LOW_F: e = jsu_pkg::emit_byte(e, jsu_pkg::CTL_FF);
                    jsu_pkg::CH_LOW_U:
                    begin
                        mode_next    = M_HEX;
                        hex_cnt_next = 3'd0;
                        code_next    = 16'd0;
                    end
                    default: e = jsu_pkg::emit_byte(e, char_byte);
                endcase
            end
        end

        // Clip to the room left in the destination
        bw_plus1 = {1'b0, bw} + 17'd1;
        if (bw_plus1 < {1'b0, cap_reg})
            room = cap_reg - bw - 16'd1;
        else
            room = 16'd0;
        if (room < 16'(e.count))
            keep = room[jsu_pkg::EMIT_CNT_W-1:0];
        else
            keep = e.count;
        bw_next = bw + 16'(keep);

        job.bytes = e.bytes;
        job.count = keep;
        job.done  = done;
        job_live  = (keep != '0) || done;
    end

    // Hold decoder state and the capacity register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg    <= M_IDLE;
            hex_cnt_reg <= 3'd0;
            code_reg    <= 16'd0;
            high_reg    <= 16'd0;
            bw_reg      <= 16'd0;
            cap_reg     <= jsu_pkg::CAP_RESET;
        end
        else
        begin
            if (cfg_wr_en)
                cap_reg <= cfg_wr_data;
            if (take)
            begin
                mode_reg    <= mode_next;
                hex_cnt_reg <= hex_cnt_next;
                code_reg    <= code_next;
                high_reg    <= high_next;
                bw_reg      <= bw_next;
            end
        end
    end

endmodule

`default_nettype wire

// ----- hdl/jsu_queue.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jsu_queue (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              push,
    input  wire jsu_pkg::job_t     push_job,
    input  wire logic              pop,
    output logic                   full,
    output jsu_pkg::q_head_t       head
);

    jsu_pkg::job_t                  slot_reg [jsu_pkg::QDEPTH];
    logic [jsu_pkg::QPTR_W-1:0]     wr_ptr_reg, rd_ptr_reg;
    logic [jsu_pkg::QCNT_W-1:0]     cnt_reg;
    logic                           do_push, do_pop;

    assign full       = (cnt_reg == jsu_pkg::QCNT_W'(jsu_pkg::QDEPTH));
    assign do_push    = push && !full;
    assign do_pop     = pop && (cnt_reg != '0);
    assign head.valid = (cnt_reg != '0);
    assign head.job   = slot_reg[rd_ptr_reg];

    // Store entries
    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_job;
    end

    // Advance pointers and fill level
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end
        else
        begin
            if (do_push)
                wr_ptr_reg <= (wr_ptr_reg == jsu_pkg::QPTR_W'(jsu_pkg::QDEPTH - 1)) ?
                              '0 : wr_ptr_reg + jsu_pkg::QPTR_W'(1);
            if (do_pop)
                rd_ptr_reg <= (rd_ptr_reg == jsu_pkg::QPTR_W'(jsu_pkg::QDEPTH - 1)) ?
                              '0 : rd_ptr_reg + jsu_pkg::QPTR_W'(1);
            if (do_push && !do_pop)
                cnt_reg <= cnt_reg + jsu_pkg::QCNT_W'(1);
            else if (do_pop && !do_push)
                cnt_reg <= cnt_reg - jsu_pkg::QCNT_W'(1);
        end
    end

endmodule

`default_nettype wire

// ----- hdl/jsu_back.sv -----
`timescale 1ns / 1ps
`default_nettype none

module jsu_back (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire jsu_pkg::q_head_t  head,
    output logic                   pop,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   byte_valid,
    output logic                   value_done,
    output logic                   last
);

    logic [jsu_pkg::EMIT_CNT_W-1:0] pos_reg, pos_next, total;
    logic                           out_valid_reg, load, is_byte, is_final;
    logic [7:0]                     out_byte_reg;
    logic                           byte_valid_reg, value_done_reg, last_reg;

    // Pick the result at the current position of the head entry
    always_comb
    begin
        total    = head.job.count + jsu_pkg::EMIT_CNT_W'(head.job.done);
        load     = head.valid && (!out_valid_reg || out_ready);
        is_byte  = (pos_reg < head.job.count);
        is_final = ((pos_reg + jsu_pkg::EMIT_CNT_W'(1)) == total);
        pos_next = is_final ? '0 : pos_reg + jsu_pkg::EMIT_CNT_W'(1);
        pop      = load && is_final;
    end

    // Hold the output beat until it is taken
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            pos_reg       <= '0;
        end
        else if (load)
        begin
            out_valid_reg <= 1'b1;
            pos_reg       <= pos_next;
        end
        else if (out_ready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (load)
        begin
            out_byte_reg   <= is_byte ? head.job.bytes[pos_reg] : 8'd0;
            byte_valid_reg <= is_byte;
            value_done_reg <= !is_byte;
            last_reg       <= is_final;
        end
    end

    assign out_valid  = out_valid_reg;
    assign out_byte   = out_byte_reg;
    assign byte_valid = byte_valid_reg;
    assign value_done = value_done_reg;
    assign last       = last_reg;

endmodule

`default_nettype wire

// ----- hdl/json_string_unescape_utf8.sv -----
// The results of an item are registered in the job queue and then in the output register.
// Throughput: one item per cycle while each item gives at most one result and out_ready
// stays high; an item with more results holds the single output register until each is
// taken, and a two-entry job queue lets decoding run ahead until it fills.
// Reset: rst_n clears decoder state to idle, empties the queue and output, capacity 260.
`timescale 1ns / 1ps
`default_nettype none
`include "json_string_unescape_utf8_macros.svh"

module json_string_unescape_utf8 (
    input  wire logic              clk,
    input  wire logic              rst_n,
    input  wire logic              cfg_wr_en,
    input  wire logic [15:0]       cfg_wr_data,
    input  wire logic              in_valid,
    output logic                   in_ready,
    input  wire logic [7:0]        char_byte,
    input  wire logic              first_char,
    input  wire logic              end_of_text,
    output logic                   out_valid,
    input  wire logic              out_ready,
    output logic [7:0]             out_byte,
    output logic                   byte_valid,
    output logic                   value_done,
    output logic                   last
);

    jsu_pkg::job_t    job;
    jsu_pkg::q_head_t head;
    logic             job_live, take, q_full, pop;

    assign in_ready = !q_full;
    assign take     = in_valid && in_ready;

    jsu_front u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .char_byte   (char_byte),
        .first_char  (first_char),
        .end_of_text (end_of_text),
        .take        (take),
        .job         (job),
        .job_live    (job_live)
    );

    jsu_queue u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (take && job_live),
        .push_job (job),
        .pop      (pop),
        .full     (q_full),
        .head     (head)
    );

    jsu_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .head       (head),
        .pop        (pop),
        .out_valid  (out_valid),
        .out_ready  (out_ready),
        .out_byte   (out_byte),
        .byte_valid (byte_valid),
        .value_done (value_done),
        .last       (last)
    );

    // A close beat carries no byte and ends its item
    `JSU_ASSERT_NOW(a_done_closes, out_valid && value_done, last && !byte_valid && (out_byte == 8'd0), "close beat must be last and empty")
    // Every beat is either a byte or the close
    `JSU_ASSERT_NOW(a_beat_kind, out_valid, byte_valid != value_done, "beat must be a byte or the close")
    // A popped entry came from a valid head
    `JSU_ASSERT_NOW(a_pop_has_head, pop, head.valid && (head.job.count != '0 || head.job.done), "pop of empty or blank entry")
    // A full queue blocks input on the next cycle unless the back drains it
    `JSU_ASSERT_NEXT(a_full_blocks, q_full && !pop, !in_ready, "input taken while queue full")

endmodule

`default_nettype wire
